FILE: rtl/gfpe_pkg.sv
// gfpe_pkg: shared types, codes and GF(2^8) multiply for the polynomial evaluator.
// No dependencies; used by gfpe_cell and gf256_poly_eval_with_derivative.
`default_nettype none

package gfpe_pkg;

  localparam int unsigned ELEM_W     = 8;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned IN_DATA_W  = 16;
  localparam logic [ELEM_W-1:0] POLY_RESET = 8'd29;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_t;

  typedef struct packed {
    logic              load;
    logic [IDX_W-1:0]  index;
    logic [ELEM_W-1:0] data;
  } coef_wr_t;

  typedef struct packed {
    logic              adv;
    logic              deriv;
    logic [ELEM_W-1:0] point;
    logic [ELEM_W-1:0] poly;
  } eval_ctl_t;

  // carry-less product reduced by x^8 + poly
  function automatic logic [ELEM_W-1:0] gf_mul(input logic [ELEM_W-1:0] a,
                                              input logic [ELEM_W-1:0] b,
                                              input logic [ELEM_W-1:0] poly);
    logic [2*ELEM_W-1:0] prod;
    logic [2*ELEM_W-1:0] full;
    prod = '0;
    full = {7'd0, 1'b1, poly};
    for (int i = 0; i < 8; i++) begin
      if (b[i]) prod = prod ^ ({8'd0, a} << i);
    end
    for (int i = 15; i > 7; i--) begin
      if (prod[i]) prod = prod ^ (full << (i - 8));
    end
    return prod[ELEM_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/gf256_poly_eval_with_derivative.sv
// gf256_poly_eval_with_derivative: GF(2^8) Horner evaluator over a row of coefficient cells.
// Depends on gfpe_pkg and gfpe_cell.
//
//  channel | dir | fields
//  in_     | in  | tuser: op; tdata: coef_index[3:0], value[11:4], deriv_mode[12]
//  out_    | out | tdata: eval_result[7:0]
//  cfg_    | in  | wr_data: reduction_poly, written when wr_en is high
//
// An evaluate walks the accumulator down the cell row, one cell per cycle while the
// row is not held, from the top cell to cell 0 and then into the output register.
// in_tready is low while an evaluate is in the row; loads proceed while a result waits.
// A stalled result holds the row. Reset clears the store to zero and poly to 0x1D.
`default_nettype none

module gf256_poly_eval_with_derivative #(
  parameter int NUM_COEFS = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [15:0] in_tdata,   // coef_index[3:0], value[11:4], deriv_mode[12], zero
  input  wire  [0:0]  in_tuser,   // op[0]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata,  // eval_result[7:0]
  input  wire         cfg_wr_en,
  input  wire  [7:0]  cfg_wr_data
);

  localparam int EW = gfpe_pkg::ELEM_W;

  logic          in_fire, eval_fire;
  gfpe_pkg::op_t in_op;

  logic [EW-1:0] poly_r, poly_nxt;
  logic [EW-1:0] point_r, point_nxt;
  logic          deriv_r, deriv_nxt;
  logic          busy_r, busy_nxt;
  logic          start_r, start_nxt;
  logic          out_vld_r, out_vld_nxt;
  logic [EW-1:0] out_data_r, out_data_nxt;
  logic          advance, c0_xfer;

  gfpe_pkg::coef_wr_t  wr;
  gfpe_pkg::eval_ctl_t ctl;

  logic [NUM_COEFS-1:0] cell_vld;
  logic [EW-1:0]        cell_acc [NUM_COEFS];

  assign in_op     = gfpe_pkg::op_t'(in_tuser[0]);
  assign in_tready = !busy_r;
  assign in_fire   = in_tvalid && in_tready;
  assign eval_fire = in_fire && (in_op == gfpe_pkg::OP_EVAL);

  assign advance = !(cell_vld[0] && out_vld_r && !out_tready);
  assign c0_xfer = cell_vld[0] && advance;

  assign wr.load  = in_fire && (in_op == gfpe_pkg::OP_LOAD);
  assign wr.index = in_tdata[3:0];
  assign wr.data  = in_tdata[11:4];

  assign ctl.adv   = advance;
  assign ctl.deriv = deriv_r;
  assign ctl.point = point_r;
  assign ctl.poly  = poly_r;

  always_comb begin
    poly_nxt     = cfg_wr_en ? cfg_wr_data : poly_r;
    point_nxt    = eval_fire ? in_tdata[11:4] : point_r;
    deriv_nxt    = eval_fire ? in_tdata[12] : deriv_r;
    start_nxt    = eval_fire ? 1'b1 : (advance ? 1'b0 : start_r);
    busy_nxt     = eval_fire ? 1'b1 : (c0_xfer ? 1'b0 : busy_r);
    out_vld_nxt  = c0_xfer ? 1'b1 : (out_tready ? 1'b0 : out_vld_r);
    out_data_nxt = c0_xfer ? cell_acc[0] : out_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r    <= gfpe_pkg::POLY_RESET;
      start_r   <= 1'b0;
      busy_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      poly_r    <= poly_nxt;
      start_r   <= start_nxt;
      busy_r    <= busy_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    point_r    <= point_nxt;
    deriv_r    <= deriv_nxt;
    out_data_r <= out_data_nxt;
  end

  // accumulator enters at the top cell and moves towards cell 0
  for (genvar j = 0; j < NUM_COEFS; j++) begin : g_cell
    logic          vin;
    logic [EW-1:0] ain;
    if (j == NUM_COEFS - 1) begin : g_top
      assign vin = start_r;
      assign ain = '0;
    end else begin : g_mid
      assign vin = cell_vld[j+1];
      assign ain = cell_acc[j+1];
    end
    gfpe_cell #(
      .CELL_IDX(j)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .wr     (wr),
      .ctl    (ctl),
      .vld_in (vin),
      .acc_in (ain),
      .vld_out(cell_vld[j]),
      .acc_out(cell_acc[j])
    );
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cell_vld, start_r}))
    else $error("more than one evaluation in the cell row");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (cell_vld == '0) && !start_r)
    else $error("cell row active while idle");

  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    eval_fire |=> busy_r && start_r)
    else $error("evaluate transfer did not start the row");

  a_result_slot: assert property (@(posedge clk) disable iff (!rst_n)
    c0_xfer |=> out_vld_r && !busy_r)
    else $error("result not registered on completion");

endmodule

`default_nettype wire

FILE: rtl/gfpe_cell.sv
// gfpe_cell: one coefficient of the store plus one Horner step.
// Depends on gfpe_pkg.
`default_nettype none

module gfpe_cell #(
  parameter int CELL_IDX = 0
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  gfpe_pkg::coef_wr_t              wr,
  input  gfpe_pkg::eval_ctl_t             ctl,
  input  wire                             vld_in,
  input  wire  [gfpe_pkg::ELEM_W-1:0]     acc_in,
  output logic                            vld_out,
  output logic [gfpe_pkg::ELEM_W-1:0]     acc_out
);

  localparam bit ODD_CELL = (CELL_IDX % 2) == 1;

  logic [gfpe_pkg::ELEM_W-1:0] coef_r, coef_nxt;
  logic [gfpe_pkg::ELEM_W-1:0] acc_r, acc_nxt;
  logic                        vld_r, vld_nxt;
  logic [gfpe_pkg::ELEM_W-1:0] coef_eff;
  logic                        wr_hit;

  assign wr_hit   = wr.load && (32'(wr.index) == 32'(CELL_IDX));
  assign coef_eff = (ODD_CELL && ctl.deriv) ? '0 : coef_r;

  always_comb begin
    coef_nxt = wr_hit ? wr.data : coef_r;
    vld_nxt  = ctl.adv ? vld_in : vld_r;
    acc_nxt  = acc_r;
    if (ctl.adv && vld_in) begin
      acc_nxt = gfpe_pkg::gf_mul(acc_in, ctl.point, ctl.poly) ^ coef_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
      vld_r  <= 1'b0;
    end else begin
      coef_r <= coef_nxt;
      vld_r  <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign vld_out = vld_r;
  assign acc_out = acc_r;

endmodule

`default_nettype wire

FILE: tb/sv/tb_gf256_poly_eval_with_derivative.sv
// Self-checking bench for gf256_poly_eval_with_derivative: coefficient loads, Horner evaluation
// and derivative mode across several field polynomials, with bursty input and output stalls.
// Depends on gfpe_pkg and the RTL of the evaluator only.
`default_nettype none

module tb_gf256_poly_eval_with_derivative;

  localparam int NUM_COEFS   = 16;
  localparam int IDLE_PAD    = 24;    // evaluate walks NUM_COEFS cells, plus margin
  localparam int DRAIN_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    gfpe_pkg::op_t op;
    logic [3:0]    index;
    logic [7:0]    value;
    logic          deriv;
  } coef_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // coef_index[3:0], value[11:4], deriv_mode[12], zero
  logic [0:0]  in_tuser = '0;   // op[0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // eval_result[7:0]
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;

  // predictor state
  logic [7:0]  coef_mem [NUM_COEFS];
  logic [7:0]  poly_lo;
  logic [7:0]  pending_evals [$];
  logic [7:0]  eval_want;

  int mismatch_count = 0;
  int loads_sent = 0;
  int evals_sent = 0;
  int results_seen = 0;
  int polys_used = 0;

  // sender and receiver pacing
  bit gaps_on = 1'b0;
  int burst_left = 0;
  int stall_pct = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;

  always #5 clk = ~clk;

  gf256_poly_eval_with_derivative #(.NUM_COEFS(NUM_COEFS)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  function automatic logic [7:0] field_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] prod;
    logic [7:0] sh;
    prod = '0;
    sh = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) prod = prod ^ sh;
      sh = sh[7] ? ((sh << 1) ^ poly_lo) : (sh << 1);
    end
    return prod;
  endfunction

  function automatic logic [7:0] poly_at(input logic [7:0] x, input logic deriv);
    logic [7:0] acc;
    logic [7:0] c;
    acc = '0;
    for (int j = NUM_COEFS - 1; j >= 0; j--) begin
      c = (deriv && (j % 2 == 1)) ? 8'h00 : coef_mem[j];
      acc = field_mul(acc, x) ^ c;
    end
    return acc;
  endfunction

  function automatic void apply_item(input coef_item_t it);
    if (it.op == gfpe_pkg::OP_LOAD) begin
      if (it.index < NUM_COEFS) coef_mem[it.index] = it.value;
      loads_sent++;
    end else begin
      pending_evals.push_back(poly_at(it.value, it.deriv));
      evals_sent++;
    end
  endfunction

  function automatic coef_item_t make_item(input gfpe_pkg::op_t op, input logic [3:0] index,
                                           input logic [7:0] value, input logic deriv);
    coef_item_t it;
    it.op = op;
    it.index = index;
    it.value = value;
    it.deriv = deriv;
    return it;
  endfunction

  function automatic coef_item_t rand_item();
    coef_item_t it;
    it.op = $urandom_range(0, 1) ? gfpe_pkg::OP_EVAL : gfpe_pkg::OP_LOAD;
    it.index = 4'($urandom_range(0, 15));
    case ($urandom_range(0, 7))
      0: it.value = 8'h00;
      1: it.value = 8'hFF;
      2: it.value = 8'h01;
      default: it.value = 8'($urandom_range(0, 255));
    endcase
    it.deriv = 1'($urandom_range(0, 1));
    return it;
  endfunction

  task automatic send_item(input coef_item_t it);
    if (gaps_on && burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    in_tvalid <= 1'b1;
    in_tuser <= it.op;
    in_tdata <= {3'b000, it.deriv, it.value, it.index};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (burst_left > 0) burst_left--;
    apply_item(it);
  endtask

  task automatic wait_idle();
    int n;
    n = 0;
    in_tvalid <= 1'b0;
    while (pending_evals.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    if (pending_evals.size() != 0) begin
      foreach (pending_evals[k])
        $display("%0t: missing result: expected %02h, actual none", $time, pending_evals[k]);
      mismatch_count += pending_evals.size();
      pending_evals.delete();
    end
    repeat (IDLE_PAD) @(posedge clk);
  endtask

  task automatic set_field_poly(input logic [7:0] p);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= p;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    poly_lo = p;
    polys_used++;
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) send_item(rand_item());
  endtask

  // result checking
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_evals.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %02h", $time, out_tdata);
        mismatch_count++;
      end else begin
        eval_want = pending_evals.pop_front();
        results_seen++;
        if (out_tdata !== eval_want) begin
          $display("%0t: eval_result mismatch: expected %02h, actual %02h",
                   $time, eval_want, out_tdata);
          mismatch_count++;
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic test_reset_state();
    gaps_on = 1'b0;
    stall_pct = 0;
    send_item(make_item(gfpe_pkg::OP_EVAL, 4'd0, 8'h00, 1'b0));
    send_item(make_item(gfpe_pkg::OP_EVAL, 4'd15, 8'hFF, 1'b0));
    send_item(make_item(gfpe_pkg::OP_EVAL, 4'd7, 8'h53, 1'b1));
    send_item(make_item(gfpe_pkg::OP_EVAL, 4'd0, 8'h02, 1'b1));
    wait_idle();
  endtask

  task automatic test_directed();
    send_item(make_item(gfpe_pkg::OP_LOAD, 4'd0, 8'hFF, 1'b0));
    send_item(make_item(gfpe_pkg::OP_LOAD, 4'd15, 8'hFF, 1'b1));   // deriv ignored on load
    send_item(make_item(gfpe_pkg::OP_LOAD, 4'd1, 8'h01, 1'b0));
    send_item(make_item(gfpe_pkg::OP_LOAD, 4'd2, 8'h80, 1'b1));
    send_item(make_item(gfpe_pkg::OP_EVAL, 4'd0, 8'h00, 1'b0));
    send_item(make_item(gfpe_pkg::OP_EVAL, 4'd9, 8'h01, 1'b0));
    send_item(make_item(gfpe_pkg::OP_EVAL, 4'd15, 8'h01, 1'b1));
    send_item(make_item(gfpe_pkg::OP_EVAL, 4'd0, 8'hFF, 1'b0));
    send_item(make_item(gfpe_pkg::OP_EVAL, 4'd0, 8'hFF, 1'b1));
    send_item(make_item(gfpe_pkg::OP_EVAL, 4'd3, 8'h02, 1'b1));
    send_item(make_item(gfpe_pkg::OP_EVAL, 4'd3, 8'h80, 1'b0));    // reduction of top bit
    send_item(make_item(gfpe_pkg::OP_LOAD, 4'd0, 8'h00, 1'b0));
    send_item(make_item(gfpe_pkg::OP_LOAD, 4'd15, 8'h00, 1'b0));
    send_item(make_item(gfpe_pkg::OP_LOAD, 4'd7, 8'hA5, 1'b0));
    send_item(make_item(gfpe_pkg::OP_EVAL, 4'd15, 8'h80, 1'b0));
    send_item(make_item(gfpe_pkg::OP_EVAL, 4'd0, 8'h80, 1'b1));
    send_item(make_item(gfpe_pkg::OP_EVAL, 4'd0, 8'h00, 1'b1));
    wait_idle();
  endtask

  task automatic test_field_polys();
    logic [7:0] polys [4];
    polys[0] = 8'h00;
    polys[1] = 8'hFF;
    polys[2] = 8'h2B;
    polys[3] = 8'($urandom_range(0, 255));
    gaps_on = 1'b1;
    stall_pct = 25;
    foreach (polys[k]) begin
      set_field_poly(polys[k]);
      send_random(40);
    end
    set_field_poly(gfpe_pkg::POLY_RESET);
    send_random(20);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 8; phase++) begin
      if (phase % 3 == 1) set_field_poly(8'($urandom_range(0, 255)));
      gaps_on = (phase % 4 != 0);
      case (phase % 4)
        0: stall_pct = 0;
        1: stall_pct = 20;
        2: stall_pct = 60;
        default: stall_pct = $urandom_range(0, 90);
      endcase
      send_random(65);
    end
    wait_idle();
  endtask

  task automatic test_backpressure();
    gaps_on = 1'b0;
    stall_pct = 0;
    hold_seq <= hold_seq + 1;
    for (int i = 0; i < 30; i++) begin
      if (i % 4 == 0) send_item(make_item(gfpe_pkg::OP_LOAD, 4'($urandom_range(0, 15)),
                                          8'($urandom_range(0, 255)), 1'b0));
      else send_item(make_item(gfpe_pkg::OP_EVAL, 4'd0, 8'($urandom_range(0, 255)),
                               1'($urandom_range(0, 1))));
    end
    wait_idle();
  endtask

  initial begin
    foreach (coef_mem[k]) coef_mem[k] = 8'h00;
    poly_lo = gfpe_pkg::POLY_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_reset_state();
    test_directed();
    test_field_polys();
    test_random_traffic();
    test_backpressure();
    wait_idle();

    $display("covered %0d loads and %0d evaluates, %0d results checked, %0d field polys",
             loads_sent, evals_sent, results_seen, polys_used);
    $display("mismatches: %0d", mismatch_count);
    if (mismatch_count == 0) begin
      $display("gf256_poly_eval_with_derivative regression: pass");
    end else begin
      $display("gf256_poly_eval_with_derivative regression: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout waiting on the evaluator");
    $display("gf256_poly_eval_with_derivative regression: fail");
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
rtl/gfpe_pkg.sv
rtl/gfpe_cell.sv
rtl/gf256_poly_eval_with_derivative.sv
tb/sv/tb_gf256_poly_eval_with_derivative.sv
